FILE: rtl/mlfd_pkg.sv
package mlfd_pkg;

  localparam logic [15:0] START_MARK       = 16'd16018;
  localparam logic [15:0] END_MARK         = 16'd16108;
  localparam logic [15:0] MIN_FRAME_LENGTH = 16'd8;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd8192;

  typedef enum logic [3:0] {
    PH_START_LO = 4'd0,
    PH_START_HI = 4'd1,
    PH_LEN_LO   = 4'd2,
    PH_LEN_HI   = 4'd3,
    PH_SID_LO   = 4'd4,
    PH_SID_HI   = 4'd5,
    PH_PAYLOAD  = 4'd6,
    PH_END_LO   = 4'd7,
    PH_END_HI   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_GOOD       = 3'd1,
    KIND_BAD_START  = 3'd2,
    KIND_BAD_END    = 3'd3,
    KIND_BAD_LENGTH = 3'd4
  } kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_low_byte;
    logic [15:0] total_length;
    logic [15:0] current_service;
    logic [15:0] bytes_seen;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] service_id;
    logic [15:0] frame_length;
  } parse_result_t;

endpackage

FILE: rtl/mlfd_in_if.sv
interface mlfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/mlfd_out_if.sv
interface mlfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] service_id;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output payload_byte, output service_id,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input service_id,
                  input frame_length, output ready);
endinterface

FILE: rtl/mlfd_parser.sv
module mlfd_parser
  import mlfd_pkg::*;
(
  input  parse_state_t  st,
  input  logic [7:0]    rx_byte,
  input  logic [15:0]   max_len,
  output parse_state_t  st_nxt,
  output parse_result_t res
);

  logic [15:0] word;
  logic        start_bad;
  logic        len_bad;
  logic [15:0] seen_inc;
  logic [16:0] seen_plus_end;

  assign word          = {rx_byte, st.held_low_byte};
  assign start_bad     = (word != START_MARK);
  assign len_bad       = (word < MIN_FRAME_LENGTH) || (word > max_len);
  assign seen_inc      = st.bytes_seen + 16'd1;
  assign seen_plus_end = {1'b0, seen_inc} + 17'd2;

  // Next state. Any verdict returns to hunting with all fields cleared.
  always_comb begin
    st_nxt = st;
    unique case (st.phase)
      PH_START_HI: begin
        if (start_bad) begin
          st_nxt = '0;
          st_nxt.phase = PH_START_LO;
        end else begin
          st_nxt.bytes_seen = 16'd2;
          st_nxt.phase      = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        st_nxt.held_low_byte = rx_byte;
        st_nxt.bytes_seen    = 16'd3;
        st_nxt.phase         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len_bad) begin
          st_nxt = '0;
          st_nxt.phase = PH_START_LO;
        end else begin
          st_nxt.total_length = word;
          st_nxt.bytes_seen   = 16'd4;
          st_nxt.phase        = PH_SID_LO;
        end
      end
      PH_SID_LO: begin
        st_nxt.held_low_byte = rx_byte;
        st_nxt.bytes_seen    = 16'd5;
        st_nxt.phase         = PH_SID_HI;
      end
      PH_SID_HI: begin
        st_nxt.current_service = word;
        st_nxt.bytes_seen      = 16'd6;
        st_nxt.phase = (st.total_length <= MIN_FRAME_LENGTH) ? PH_END_LO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        st_nxt.bytes_seen = seen_inc;
        if (seen_plus_end >= {1'b0, st.total_length}) begin
          st_nxt.phase = PH_END_LO;
        end
      end
      PH_END_LO: begin
        st_nxt.held_low_byte = rx_byte;
        st_nxt.bytes_seen    = seen_inc;
        st_nxt.phase         = PH_END_HI;
      end
      PH_END_HI: begin
        st_nxt = '0;
        st_nxt.phase = PH_START_LO;
      end
      default: begin
        // First start byte, also taken for any unused phase code.
        st_nxt               = '0;
        st_nxt.held_low_byte = rx_byte;
        st_nxt.bytes_seen    = 16'd1;
        st_nxt.phase         = PH_START_HI;
      end
    endcase
  end

  // Result word for this byte, if any.
  always_comb begin
    res = '0;
    unique case (st.phase)
      PH_START_HI: begin
        if (start_bad) begin
          res.valid = 1'b1;
          res.kind  = KIND_BAD_START;
        end
      end
      PH_LEN_HI: begin
        if (len_bad) begin
          res.valid        = 1'b1;
          res.kind         = KIND_BAD_LENGTH;
          res.frame_length = word;
        end
      end
      PH_PAYLOAD: begin
        res.valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.service_id   = st.current_service;
      end
      PH_END_HI: begin
        res.valid        = 1'b1;
        res.kind         = (word == END_MARK) ? KIND_GOOD : KIND_BAD_END;
        res.service_id   = st.current_service;
        res.frame_length = st.total_length;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

FILE: rtl/marked_length_frame_deframer_core.sv
// An accepted byte word is registered in the input stage; its result word, if
// any, goes to the result register, which drives the output channel.
// Throughput: one byte word per cycle while the result register is not stalled,
// set by the single header/payload state update between those two registers.
// Reset: rst_n is synchronous and active low; it empties both stages, returns
// the parser to hunting for a start mark and sets max_len_r to 8192.
module marked_length_frame_deframer_core
  import mlfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mlfd_in_if.sink           in_ch,
  mlfd_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data
);

  // Configuration register: largest total frame length accepted.
  logic [15:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Input register stage. A byte sits here while the parser looks at it.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Parser state, updated only when the byte in the input stage retires.
  parse_state_t  st_r;
  parse_state_t  st_nxt;
  parse_result_t res;

  // Result register.
  logic          out_valid_r;
  parse_result_t out_r;

  logic s1_advance;

  mlfd_parser u_parser (
    .st      (st_r),
    .rx_byte (s1_byte_r),
    .max_len (max_len_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // A byte that makes no result word retires regardless of the output side.
  // A byte that makes one needs the result register to be empty or draining.
  assign s1_advance = s1_valid_r && (!res.valid || !out_valid_r || out_ch.ready);

  // The input stage takes a new byte whenever its current byte retires, so a
  // waiting result word does not hold up bytes that produce nothing.
  assign in_ch.ready = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // Hunting for the first start byte is phase code zero, so clearing the whole
  // state puts the parser there.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.payload_byte = out_r.payload_byte;
  assign out_ch.service_id   = out_r.service_id;
  assign out_ch.frame_length = out_r.frame_length;

endmodule
